// ===== src/soundex_word_match_counter_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef SOUNDEX_WORD_MATCH_COUNTER_MACROS_SVH
`define SOUNDEX_WORD_MATCH_COUNTER_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define SWMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define SWMC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/swmc_pkg.sv =====
package swmc_pkg;

    typedef logic [2:0] t_digit;

    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_COUNT_W = 16;
    localparam int USER_W = 2;

    // Bit positions in the result tuser.
    localparam int USER_END_BIT     = 0;
    localparam int USER_MATCHED_BIT = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LETTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_ONE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_TWO     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_THREE   = 2'd3;

    localparam t_digit DIGIT_NONE = 3'd0;

    // Consonant class of a lowercase letter; vowels and other letters give none.
    function automatic t_digit letter_class(input logic [CHAR_W-1:0] c);
        t_digit d;
        case (c)
            "b", "f", "p", "v":                d = 3'd1;
            "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
            "d", "t":                          d = 3'd3;
            "l":                               d = 3'd4;
            "m", "n":                          d = 3'd5;
            "r":                               d = 3'd6;
            default:                           d = DIGIT_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== src/soundex_word_match_counter.sv =====
// Soundex word match counter.
// Input stream: one sentence byte per word; s_axis_tdata holds the character
// and s_axis_tlast marks the final byte of a sentence. Words are runs of ASCII
// letters, each coded as first letter plus three consonant class digits.
// Output stream: exactly one word per input byte. tdata carries the running
// match count, tuser flags a closed word and whether its code matched the
// target, tlast repeats the sentence end; on that word the count is final.
// Targets are loaded through i_cfg_we/i_cfg_index/i_cfg_data while idle; the
// user must keep to this, as the block does not enforce it. An accepted byte
// passes through an input register and a result register, with the word
// update between them. One byte can be taken every cycle while the receiver
// does not stall, since the per-byte update is a single lookup, compare and
// counter increment. When the receiver stalls, the result register holds and
// the input register fills; s_axis_tready then drops until the output drains.
// Synchronous reset clears both valid flags, the word state, the counter and
// the target registers.
module soundex_word_match_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [swmc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [swmc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [swmc_pkg::CHAR_W-1:0]           s_axis_tdata,  // [7:0] char_code
    input  logic                                  s_axis_tlast,  // last_of_sentence
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [swmc_pkg::OUT_COUNT_W-1:0]      m_axis_tdata,  // [15:0] match_count
    output logic [swmc_pkg::USER_W-1:0]           m_axis_tuser,  // [0] word_end, [1] word_matched
    output logic                                  m_axis_tlast   // sentence_end
);

    localparam int EXT_W = (COUNT_WIDTH > swmc_pkg::OUT_COUNT_W) ?
                           COUNT_WIDTH : swmc_pkg::OUT_COUNT_W;

    // Target code.
    logic [swmc_pkg::CHAR_W-1:0] r_tgt_letter;
    swmc_pkg::t_digit            r_tgt_digit [3];

    // Input register.
    logic                        r_in_valid;
    logic [swmc_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_in_last;

    // Word state.
    logic                        r_inside;
    logic [1:0]                  r_len;
    logic [swmc_pkg::CHAR_W-1:0] r_first;
    swmc_pkg::t_digit            r_digit [3];
    swmc_pkg::t_digit            r_last_digit;
    logic [COUNT_WIDTH-1:0]      r_count;

    // Result register.
    logic                        r_out_valid;
    logic [swmc_pkg::OUT_COUNT_W-1:0] r_out_count;
    logic                        r_out_end;
    logic                        r_out_matched;
    logic                        r_out_last;

    logic                        w_out_free;
    logic                        w_step;
    logic                        w_upper;
    logic                        w_lower;
    logic                        w_letter;
    swmc_pkg::t_digit            w_class;
    logic                        w_close;
    logic                        w_matched;
    logic                        n_inside;
    logic [1:0]                  n_len;
    logic [swmc_pkg::CHAR_W-1:0] n_first;
    swmc_pkg::t_digit            n_digit [3];
    swmc_pkg::t_digit            n_last_digit;
    logic [COUNT_WIDTH-1:0]      n_count;
    logic [EXT_W-1:0]            w_count_ext;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    assign w_upper  = (r_in_char >= "A") && (r_in_char <= "Z");
    assign w_lower  = (r_in_char >= "a") && (r_in_char <= "z");
    assign w_letter = w_upper || w_lower;
    assign w_class  = swmc_pkg::letter_class(r_in_char);
    assign w_close  = (w_letter && r_in_last) || (!w_letter && r_inside);

    always_comb begin
        n_inside     = r_inside;
        n_len        = r_len;
        n_first      = r_first;
        n_digit      = r_digit;
        n_last_digit = r_last_digit;
        if (w_letter && !r_inside) begin
            n_inside     = 1'b1;
            n_len        = 2'd0;
            n_first      = r_in_char;
            n_digit[0]   = swmc_pkg::DIGIT_NONE;
            n_digit[1]   = swmc_pkg::DIGIT_NONE;
            n_digit[2]   = swmc_pkg::DIGIT_NONE;
            n_last_digit = swmc_pkg::DIGIT_NONE;
        end else if (w_lower && (w_class != swmc_pkg::DIGIT_NONE) &&
                     (w_class != r_last_digit) && (r_len != 2'd3)) begin
            n_digit[r_len] = w_class;
            n_len          = r_len + 2'd1;
            n_last_digit   = w_class;
        end

        // The code is compared after this byte has been folded in.
        w_matched = w_close && (n_first == r_tgt_letter) &&
                    (n_digit[0] == r_tgt_digit[0]) &&
                    (n_digit[1] == r_tgt_digit[1]) &&
                    (n_digit[2] == r_tgt_digit[2]);

        n_count = r_count;
        if (w_matched && (r_count != {COUNT_WIDTH{1'b1}})) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
        w_count_ext = EXT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_letter   <= '0;
            r_tgt_digit[0] <= swmc_pkg::DIGIT_NONE;
            r_tgt_digit[1] <= swmc_pkg::DIGIT_NONE;
            r_tgt_digit[2] <= swmc_pkg::DIGIT_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swmc_pkg::CFG_TARGET_LETTER: r_tgt_letter   <= i_cfg_data;
                swmc_pkg::CFG_DIGIT_ONE:     r_tgt_digit[0] <= i_cfg_data[2:0];
                swmc_pkg::CFG_DIGIT_TWO:     r_tgt_digit[1] <= i_cfg_data[2:0];
                swmc_pkg::CFG_DIGIT_THREE:   r_tgt_digit[2] <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_len        <= 2'd0;
            r_first      <= '0;
            r_digit[0]   <= swmc_pkg::DIGIT_NONE;
            r_digit[1]   <= swmc_pkg::DIGIT_NONE;
            r_digit[2]   <= swmc_pkg::DIGIT_NONE;
            r_last_digit <= swmc_pkg::DIGIT_NONE;
            r_count      <= '0;
        end else if (w_step) begin
            if (w_close || r_in_last) begin
                r_inside     <= 1'b0;
                r_len        <= 2'd0;
                r_first      <= '0;
                r_digit[0]   <= swmc_pkg::DIGIT_NONE;
                r_digit[1]   <= swmc_pkg::DIGIT_NONE;
                r_digit[2]   <= swmc_pkg::DIGIT_NONE;
                r_last_digit <= swmc_pkg::DIGIT_NONE;
            end else begin
                r_inside     <= n_inside;
                r_len        <= n_len;
                r_first      <= n_first;
                r_digit      <= n_digit;
                r_last_digit <= n_last_digit;
            end
            r_count <= r_in_last ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_step) begin
            r_out_count   <= w_count_ext[swmc_pkg::OUT_COUNT_W-1:0];
            r_out_end     <= w_close;
            r_out_matched <= w_matched;
            r_out_last    <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;
    assign m_axis_tuser  = {r_out_matched, r_out_end};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== src/swmc_checker.sv =====
`include "soundex_word_match_counter_macros.svh"

module swmc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [swmc_pkg::OUT_COUNT_W-1:0]   m_axis_tdata,
    input logic [swmc_pkg::USER_W-1:0]        m_axis_tuser,
    input logic                               m_axis_tlast
);

    // A stalled result must stay put until the receiver takes it.
    `SWMC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

    // A match is only ever reported together with a closed word.
    `SWMC_ASSERT(a_match_needs_end, m_axis_tvalid && m_axis_tuser[swmc_pkg::USER_MATCHED_BIT] |-> m_axis_tuser[swmc_pkg::USER_END_BIT], "match flagged without word end")

    // With nothing waiting at the output the block must take input.
    `SWMC_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")

    // Reset empties the result register.
    `SWMC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind soundex_word_match_counter swmc_checker u_swmc_checker (.*);

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swmc_pkg::*;

    localparam int COUNT_W = 16;

    typedef logic [7:0] byte_q_t[$];

    // Tracks the word state and the match counter of the block, and holds one
    // expected word per accepted input byte.
    class soundex_counter_model;
        typedef struct packed {
            logic                   word_end;
            logic                   word_matched;
            logic [OUT_COUNT_W-1:0] match_count;
            logic                   sentence_end;
        } word_result_t;

        // Consonant class of 'a' through 'z', one character per letter.
        string class_table = "01230120022455012623010202";

        logic [7:0]         tgt_letter;
        t_digit             tgt_d1, tgt_d2, tgt_d3;
        logic               in_word;
        int                 n_digits;
        logic [7:0]         first_letter;
        t_digit             digits[3];
        t_digit             prev_digit;
        logic [COUNT_W-1:0] match_total;
        word_result_t       words_due[$];
        int                 failures;

        function new();
            tgt_letter = '0;
            tgt_d1 = DIGIT_NONE;
            tgt_d2 = DIGIT_NONE;
            tgt_d3 = DIGIT_NONE;
            match_total = '0;
            failures = 0;
            clear_word();
        endfunction

        function void clear_word();
            in_word = 1'b0;
            n_digits = 0;
            first_letter = '0;
            digits = '{DIGIT_NONE, DIGIT_NONE, DIGIT_NONE};
            prev_digit = DIGIT_NONE;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TARGET_LETTER: tgt_letter = val;
                CFG_DIGIT_ONE:     tgt_d1 = val[2:0];
                CFG_DIGIT_TWO:     tgt_d2 = val[2:0];
                CFG_DIGIT_THREE:   tgt_d3 = val[2:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            word_result_t r;
            logic         closed;
            logic         matched;
            t_digit       d;
            closed = 1'b0;
            matched = 1'b0;
            if (is_alpha(c)) begin
                if (!in_word) begin
                    clear_word();
                    in_word = 1'b1;
                    first_letter = c;
                end else if (c >= "a" && c <= "z") begin
                    d = t_digit'(class_table[c - "a"] - "0");
                    // A class equal to the last one coded in this word is skipped,
                    // however many letters stand between them.
                    if (d != DIGIT_NONE && d != prev_digit && n_digits < 3) begin
                        digits[n_digits] = d;
                        n_digits++;
                        prev_digit = d;
                    end
                end
                closed = last;
            end else begin
                closed = in_word;
            end
            if (closed) begin
                matched = first_letter == tgt_letter && digits[0] == tgt_d1 &&
                          digits[1] == tgt_d2 && digits[2] == tgt_d3;
                if (matched && match_total != {COUNT_W{1'b1}})
                    match_total++;
                clear_word();
            end
            r.word_end = closed;
            r.word_matched = matched;
            r.match_count = match_total[OUT_COUNT_W-1:0];
            r.sentence_end = last;
            words_due.push_back(r);
            if (last) begin
                clear_word();
                match_total = '0;
            end
        endfunction

        function void report(string field, logic [OUT_COUNT_W-1:0] want,
                             logic [OUT_COUNT_W-1:0] got);
            failures++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_word(logic [OUT_COUNT_W-1:0] count, logic [USER_W-1:0] user,
                                 logic last);
            word_result_t want;
            if (words_due.size() == 0) begin
                report("word with nothing due, match_count", '0, count);
                return;
            end
            want = words_due.pop_front();
            if (user[USER_END_BIT] !== want.word_end)
                report("word_end", want.word_end, user[USER_END_BIT]);
            if (user[USER_MATCHED_BIT] !== want.word_matched)
                report("word_matched", want.word_matched, user[USER_MATCHED_BIT]);
            if (count !== want.match_count)
                report("match_count", want.match_count, count);
            if (last !== want.sentence_end)
                report("sentence_end", want.sentence_end, last);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_COUNT_W-1:0] m_axis_tdata;
    logic [USER_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    soundex_counter_model counter_model = new();

    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_request;

    // Index 0 holds letters without a class; index n the consonants of class n.
    string letter_sets[7] = '{"aeiouhwy", "bfpv", "cgjkqsxz", "dt", "l", "mn", "r"};

    // Code of the words that the random text is built around.
    logic [7:0] cur_letter;
    t_digit     cur_d[3];
    int         cur_nd;

    soundex_word_match_counter #(.COUNT_WIDTH(COUNT_W)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .s_axis_tlast  (s_axis_tlast),   // last_of_sentence
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] match_count
        .m_axis_tuser  (m_axis_tuser),   // [0] word_end, [1] word_matched
        .m_axis_tlast  (m_axis_tlast)    // sentence_end
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] pick(t_digit d);
        return letter_sets[d][$urandom_range(letter_sets[d].len() - 1)];
    endfunction

    // A word whose code is the current one, with classless letters, uppercase
    // letters and repeats of the previous class mixed in.
    function automatic byte_q_t code_word();
        byte_q_t w;
        int      k;
        int      f;
        int      n;
        t_digit  prev;
        w.push_back(cur_letter);
        prev = DIGIT_NONE;
        for (k = 0; k <= cur_nd; k++) begin
            n = $urandom_range(0, 2);
            for (f = 0; f < n; f++) begin
                case ($urandom_range(2))
                    0: w.push_back(pick(DIGIT_NONE));
                    1: w.push_back(8'("A" + $urandom_range(25)));
                    default: w.push_back(pick(prev));
                endcase
            end
            if (k < cur_nd) begin
                w.push_back(pick(cur_d[k]));
                prev = cur_d[k];
            end
        end
        if (cur_nd == 3)
            repeat ($urandom_range(0, 2)) w.push_back(rand_letter());
        return w;
    endfunction

    task automatic new_code();
        int     k;
        t_digit d;
        cur_letter = rand_letter();
        cur_nd = $urandom_range(0, 3);
        for (k = 0; k < 3; k++) begin
            if (k < cur_nd) begin
                do d = t_digit'($urandom_range(1, 6));
                while (k > 0 && d == cur_d[k-1]);
                cur_d[k] = d;
            end else begin
                cur_d[k] = DIGIT_NONE;
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (tx_idle_on && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        counter_model.note_byte(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s, input logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && i == s.len() - 1);
    endtask

    task automatic send_sentence(inout int sent);
        byte_q_t text;
        byte_q_t w;
        int      n_words;
        int      i;
        int      j;
        int      kind;
        n_words = $urandom_range(0, 6);
        for (i = 0; i < n_words; i++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                w = code_word();
            end else if (kind < 75) begin
                w = code_word();
                w[$urandom_range(w.size() - 1)] = rand_letter();
            end else begin
                w.delete();
                repeat ($urandom_range(1, 8)) w.push_back(rand_letter());
            end
            foreach (w[j]) text.push_back(w[j]);
            // The last word may run to the end, so that a letter closes it.
            if (i < n_words - 1 || $urandom_range(1))
                repeat ($urandom_range(1, 2))
                    text.push_back($urandom_range(99) < 60 ? 8'h20 : 8'($urandom_range(255)));
        end
        if (text.size() == 0)
            text.push_back(8'($urandom_range(255)));
        for (j = 0; j < text.size(); j++)
            send_byte(text[j], j == text.size() - 1);
        sent += text.size();
    endtask

    task automatic load_target(input logic [7:0] letter, input t_digit d1, input t_digit d2,
                               input t_digit d3);
        logic [CFG_IDX_W-1:0]  idxs[4];
        logic [CFG_DATA_W-1:0] vals[4];
        int                    k;
        idxs = '{CFG_TARGET_LETTER, CFG_DIGIT_ONE, CFG_DIGIT_TWO, CFG_DIGIT_THREE};
        // Digit registers take only the low three bits; the rest is noise.
        vals = '{letter, {5'($urandom), d1}, {5'($urandom), d2}, {5'($urandom), d3}};
        for (k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data <= vals[k];
            counter_model.set_reg(idxs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (counter_model.words_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            counter_model.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial begin
        int ph;
        int sent;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold_request = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed text against the code R163: a repeat of a class across a
        // vowel, uppercase inside a word, a full code closed by a final letter,
        // a byte with no word at all, and the letter boundaries of ASCII.
        load_target("R", 3'd1, 3'd6, 3'd3);
        send_str("Rpobrt", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_str("RuPErt", 1'b0);
        send_byte(8'h00, 1'b0);
        send_str("Rbdlm", 1'b1);
        send_str("@Z`a[", 1'b0);
        send_byte("7", 1'b1);
        drain();

        for (ph = 0; ph < 9; ph++) begin
            new_code();
            if (ph == 2)
                load_target(8'hFF, 3'd7, 3'd7, 3'd7);
            else if (ph == 5)
                load_target(8'h00, DIGIT_NONE, DIGIT_NONE, DIGIT_NONE);
            else if (ph == 7)
                load_target(cur_letter, cur_d[0], cur_d[1], 3'd7);
            else
                load_target(cur_letter, cur_d[0], cur_d[1], cur_d[2]);
            tx_idle_on = ph != 3;
            rx_idle_on = ph != 3;
            if (ph == 1)
                rx_hold_request = 1'b1;
            sent = 0;
            while (sent < 165) send_sentence(sent);
            drain();
        end

        if (counter_model.failures == 0 && counter_model.words_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
